// ===== rtl/rass_pkg.sv =====
// ----------------------------------------------------------------------------
// Random address search sequencer package
// Request and result types, command and frame codes, shared constants.
// ----------------------------------------------------------------------------
`default_nettype none
package rass_pkg;

    localparam int MaxDevices = 64;
    localparam int IdxW = $clog2(MaxDevices);

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_STOP   = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_FRAME  = 3'd4,
        CMD_READ   = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] EXIT_NONE    = 2'd0;
    localparam logic [1:0] EXIT_NOREPLY = 2'd1;
    localparam logic [1:0] EXIT_TOOMANY = 2'd2;
    localparam logic [1:0] EXIT_TIMEOUT = 2'd3;

    localparam logic [1:0] CFG_INIT_MODE = 2'd0;
    localparam logic [1:0] CFG_RAND_EN   = 2'd1;
    localparam logic [1:0] CFG_GLOBAL_TO = 2'd2;
    localparam logic [1:0] CFG_DEVICE_TO = 2'd3;

    typedef struct packed {
        logic [2:0] command;
        logic       lock_granted;
        logic       compare_yes;
        logic       reply_valid;
        logic [7:0] reply_value;
        logic [5:0] entry_index;
    } req_t;

    typedef struct packed {
        logic [3:0] frame_kind;
        logic [7:0] frame_data;
        logic [1:0] run_status;
        logic       success;
        logic [1:0] exit_code;
        logic [6:0] found_count;
        logic       release_lock;
        logic       start_accepted;
        logic [7:0] entry_high;
        logic [7:0] entry_mid;
        logic [7:0] entry_low;
        logic [7:0] entry_short;
    } rsp_t;

    typedef struct packed {
        logic [7:0]  init_address_mode;
        logic        randomize_enable;
        logic [15:0] global_timeout_ticks;
        logic [7:0]  device_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic       we;
        logic [IdxW-1:0] waddr;
        logic [31:0] wdata;
    } store_wr_t;

    function automatic logic [3:0] frame_kind_of(input logic [3:0] stage,
                                                 input logic [1:0] st);
        logic [3:0] k;
        begin
            k = 4'd0;
            case (stage)
                4'd1:  k = (st == 2'd0) ? 4'd1 : (st == 2'd1) ? 4'd2 :
                           (st == 2'd2) ? 4'd3 : 4'd0;
                4'd2:  k = 4'd4 + {2'b00, st};
                4'd3:  k = (st == 2'd0) ? 4'd6 : (st == 2'd1) ? 4'd5 : 4'd0;
                4'd4:  k = (st == 2'd0) ? 4'd4 : (st == 2'd1) ? 4'd7 : 4'd0;
                4'd5:  k = (st == 2'd0) ? 4'd4 : (st == 2'd1) ? 4'd6 :
                           (st == 2'd2) ? 4'd5 : 4'd7;
                4'd6:  k = (st == 2'd0) ? 4'd4 : (st == 2'd1) ? 4'd6 : 4'd0;
                4'd7:  k = (st == 2'd0) ? 4'd5 : (st == 2'd1) ? 4'd7 : 4'd0;
                4'd8:  k = (st == 2'd0) ? 4'd5 : (st == 2'd1) ? 4'd6 :
                           (st == 2'd2) ? 4'd7 : 4'd0;
                4'd9:  k = (st == 2'd0) ? 4'd4 : (st == 2'd1) ? 4'd5 : 4'd0;
                4'd10, 4'd11: k = (st == 2'd0) ? 4'd6 : (st == 2'd1) ? 4'd7 : 4'd0;
                4'd12: k = (st == 2'd3) ? 4'd8 : 4'd4 + {2'b00, st};
                4'd13: k = (st == 2'd0) ? 4'd9 : 4'd0;
                4'd15: k = (st == 2'd0) ? 4'd1 : 4'd0;
                default: k = 4'd0;
            endcase
            return k;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/rass_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module rass_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/rass_seq.sv =====
// ----------------------------------------------------------------------------
// Search sequencer
// Handles one request per cycle while fire is high: updates search state,
// builds the result and leaves entry reads to the found-device store.
// ----------------------------------------------------------------------------
`default_nettype none
module rass_seq (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire rass_pkg::req_t     req,
    input  wire rass_pkg::cfg_t     cfg,
    output rass_pkg::rsp_t          rsp,
    output logic                    entry_hit,
    output rass_pkg::store_wr_t     wr
);

    logic [3:0]  stage_reg, stage_next;
    logic [2:0]  step_reg, step_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  probe_reg, probe_next;
    logic [7:0]  lower_reg, lower_next;
    logic [3:0]  left_reg, left_next;
    logic [7:0]  fh_reg, fh_next, fm_reg, fm_next, fl_reg, fl_next;
    logic        pend_reg, pend_next;
    logic [1:0]  retry_reg, retry_next;
    logic [15:0] gtim_reg, gtim_next;
    logic [7:0]  dtim_reg, dtim_next;
    logic [2:0]  flags_reg, flags_next;
    logic [6:0]  count_reg, count_next;
    logic        rok_reg, rok_next;
    logic [7:0]  rbyte_reg, rbyte_next;

    logic        running;
    logic        do_settle;
    logic        emit;
    logic        rel;
    logic        acc;
    logic [7:0]  delta;
    logic [7:0]  data;
    logic [1:0]  st;
    logic [7:0]  sh;
    logic [2:0]  step_inc;
    logic [2:0]  stage_len;

    always_comb
    begin
        stage_next = stage_reg;
        step_next  = step_reg;
        status_next = status_reg;
        probe_next = probe_reg;
        lower_next = lower_reg;
        left_next  = left_reg;
        fh_next = fh_reg;
        fm_next = fm_reg;
        fl_next = fl_reg;
        pend_next = pend_reg;
        retry_next = retry_reg;
        gtim_next = gtim_reg;
        dtim_next = dtim_reg;
        flags_next = flags_reg;
        count_next = count_reg;
        rok_next = rok_reg;
        rbyte_next = rbyte_reg;
        running = (status_reg == rass_pkg::ST_RUN);
        do_settle = 1'b0;
        emit = 1'b0;
        rel = 1'b0;
        acc = 1'b0;
        delta = 8'd0;
        stage_len = 3'd2;
        step_inc = step_reg + 3'd1;
        sh = 8'd0;
        wr.we = 1'b0;
        wr.waddr = count_reg[rass_pkg::IdxW-1:0];
        wr.wdata = 32'd0;
        entry_hit = 1'b0;

        unique case (req.command)
            rass_pkg::CMD_START:
            begin
                if (!running && req.lock_granted)
                begin
                    flags_next = 3'd0;
                    retry_next = 2'd3;
                    gtim_next = cfg.global_timeout_ticks;
                    dtim_next = cfg.device_timeout_ticks;
                    count_next = 7'd0;
                    rok_next = 1'b0;
                    rbyte_next = 8'd0;
                    status_next = rass_pkg::ST_RUN;
                    acc = 1'b1;
                    pend_next = 1'b0;
                    stage_next = 4'd1;
                    step_next = 3'd0;
                    emit = 1'b1;
                end
                else
                begin
                    status_next = rass_pkg::ST_DONE;
                end
            end
            rass_pkg::CMD_STOP:
            begin
                if (running)
                begin
                    do_settle = 1'b1;
                    emit = 1'b1;
                end
            end
            rass_pkg::CMD_TICK:
            begin
                if (running)
                begin
                    if (gtim_reg != 16'd0)
                    begin
                        gtim_next = gtim_reg - 16'd1;
                    end
                    else
                    begin
                        rel = 1'b1;
                    end
                    if (dtim_reg != 8'd0)
                    begin
                        dtim_next = dtim_reg - 8'd1;
                    end
                    else
                    begin
                        rel = 1'b1;
                    end
                    if (rel)
                    begin
                        flags_next = {rass_pkg::EXIT_TIMEOUT, 1'b0};
                        status_next = rass_pkg::ST_DONE;
                    end
                end
            end
            rass_pkg::CMD_CLEAR:
            begin
                status_next = rass_pkg::ST_IDLE;
            end
            rass_pkg::CMD_FRAME:
            begin
                if (running)
                begin
                    emit = 1'b1;
                    step_next = step_inc;
                    case (stage_reg)
                        4'd1: stage_len = cfg.randomize_enable ? 3'd3 : 3'd2;
                        4'd2, 4'd5, 4'd12: stage_len = 3'd4;
                        4'd8: stage_len = 3'd3;
                        4'd13, 4'd15: stage_len = 3'd1;
                        default: stage_len = 3'd2;
                    endcase
                    if (step_inc >= stage_len)
                    begin
                        step_next = 3'd0;
                        case (stage_reg)
                            4'd1: stage_next = 4'd2;
                            4'd2:
                            begin
                                if (req.compare_yes)
                                begin
                                    stage_next = 4'd3;
                                end
                                else
                                begin
                                    do_settle = 1'b1;
                                end
                            end
                            4'd3: stage_next = 4'd4;
                            4'd6: stage_next = 4'd7;
                            4'd9: stage_next = 4'd10;
                            4'd4, 4'd7, 4'd10:
                            begin
                                if (left_reg >= 4'd2)
                                begin
                                    delta = 8'd1 << (left_reg - 4'd2);
                                end
                                if (req.compare_yes)
                                begin
                                    probe_next = probe_reg - delta;
                                end
                                else
                                begin
                                    lower_next = probe_reg;
                                    probe_next = probe_reg + delta;
                                end
                                left_next = left_reg - 4'd1;
                                if (left_reg == 4'd1)
                                begin
                                    stage_next = stage_reg + 4'd1;
                                end
                            end
                            4'd5:
                            begin
                                fh_next = req.compare_yes ? lower_reg : lower_reg + 8'd1;
                                stage_next = 4'd6;
                            end
                            4'd8:
                            begin
                                fm_next = req.compare_yes ? lower_reg : lower_reg + 8'd1;
                                stage_next = 4'd9;
                            end
                            4'd11:
                            begin
                                fl_next = req.compare_yes ? lower_reg : lower_reg + 8'd1;
                                pend_next = 1'b1;
                                stage_next = 4'd12;
                            end
                            4'd12:
                            begin
                                rok_next = req.reply_valid;
                                rbyte_next = req.reply_value;
                                stage_next = 4'd13;
                            end
                            4'd13: do_settle = 1'b1;
                            4'd15:
                            begin
                                status_next = rass_pkg::ST_DONE;
                                rel = 1'b1;
                                emit = 1'b0;
                                step_next = step_inc;
                            end
                            default: stage_next = 4'd15;
                        endcase
                        if (stage_next == 4'd3 || stage_next == 4'd6 || stage_next == 4'd9)
                        begin
                            lower_next = 8'd0;
                            left_next = 4'd8;
                            probe_next = 8'd128;
                        end
                    end
                end
            end
            rass_pkg::CMD_READ:
            begin
                entry_hit = ({1'b0, req.entry_index} < count_reg) &&
                            ({1'b0, req.entry_index} < 7'(rass_pkg::MaxDevices));
            end
            default:
            begin
            end
        endcase

        if (do_settle)
        begin
            step_next = 3'd0;
            if (!pend_next)
            begin
                flags_next = {rass_pkg::EXIT_NONE, 1'b1};
                stage_next = 4'd15;
            end
            else if (count_reg < 7'(rass_pkg::MaxDevices))
            begin
                if (rok_next)
                begin
                    sh = (rbyte_next != 8'hFF) ? {1'b0, rbyte_next[7:1]} : 8'hFF;
                    wr.we = fire;
                    wr.wdata = {fh_next, fm_next, fl_next, sh};
                    count_next = count_reg + 7'd1;
                    dtim_next = cfg.device_timeout_ticks;
                    pend_next = 1'b0;
                    retry_next = 2'd3;
                    stage_next = 4'd2;
                end
                else if (retry_reg != 2'd0)
                begin
                    retry_next = retry_reg - 2'd1;
                    stage_next = 4'd2;
                end
                else
                begin
                    flags_next = {rass_pkg::EXIT_NOREPLY, 1'b0};
                    stage_next = 4'd15;
                end
            end
            else
            begin
                flags_next = {rass_pkg::EXIT_TOOMANY, 1'b0};
                count_next = 7'd65;
                stage_next = 4'd15;
            end
        end

        st = step_next[1:0];
        data = 8'd0;
        case (stage_next)
            4'd1: data = (st == 2'd1) ? cfg.init_address_mode : 8'd0;
            4'd2: data = (st != 2'd3) ? 8'hFF : 8'd0;
            4'd4, 4'd7, 4'd10: data = (st == 2'd0) ? probe_next : 8'd0;
            4'd5: data = (st == 2'd0) ? lower_next : (st != 2'd3) ? 8'hFF : 8'd0;
            4'd6: data = (st == 2'd0) ? fh_next : 8'd0;
            4'd8: data = (st == 2'd0) ? lower_next : (st == 2'd1) ? 8'hFF : 8'd0;
            4'd9: data = (st == 2'd0) ? fh_next : fm_next;
            4'd11: data = (st == 2'd0) ? lower_next : 8'd0;
            4'd12: data = (st == 2'd0) ? fh_next : (st == 2'd1) ? fm_next :
                          (st == 2'd2) ? fl_next : 8'd0;
            default: data = 8'd0;
        endcase

        rsp.frame_kind = emit ? rass_pkg::frame_kind_of(stage_next, st) : 4'd0;
        rsp.frame_data = emit ? data : 8'd0;
        rsp.run_status = status_next;
        rsp.success = flags_next[0];
        rsp.exit_code = flags_next[2:1];
        rsp.found_count = count_next;
        rsp.release_lock = rel;
        rsp.start_accepted = acc;
        rsp.entry_high = 8'd0;
        rsp.entry_mid = 8'd0;
        rsp.entry_low = 8'd0;
        rsp.entry_short = 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 4'd0;
            step_reg <= 3'd0;
            status_reg <= rass_pkg::ST_IDLE;
            probe_reg <= 8'd128;
            lower_reg <= 8'd0;
            left_reg <= 4'd8;
            fh_reg <= 8'd0;
            fm_reg <= 8'd0;
            fl_reg <= 8'd0;
            pend_reg <= 1'b0;
            retry_reg <= 2'd3;
            gtim_reg <= 16'd0;
            dtim_reg <= 8'd0;
            flags_reg <= 3'd0;
            count_reg <= 7'd0;
            rok_reg <= 1'b0;
            rbyte_reg <= 8'd0;
        end
        else if (fire)
        begin
            stage_reg <= stage_next;
            step_reg <= step_next;
            status_reg <= status_next;
            probe_reg <= probe_next;
            lower_reg <= lower_next;
            left_reg <= left_next;
            fh_reg <= fh_next;
            fm_reg <= fm_next;
            fl_reg <= fl_next;
            pend_reg <= pend_next;
            retry_reg <= retry_next;
            gtim_reg <= gtim_next;
            dtim_reg <= dtim_next;
            flags_reg <= flags_next;
            count_reg <= count_next;
            rok_reg <= rok_next;
            rbyte_reg <= rbyte_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/random_address_search_sequencer_core.sv =====
// A result is presented in the cycle after its request is accepted; entry
// reads take their data from the store's registered read port in that same cycle.
// Flow: one request per cycle; a held result does not block the next request
// while the output register can be emptied in the same cycle.
// Reset: all control state and configuration registers take their reset values at
// once; the found-device store needs no clearing pass.
// ----------------------------------------------------------------------------
// Random address search sequencer
// Top level: request and result handshakes, configuration and device store.
// ----------------------------------------------------------------------------
`default_nettype none
module random_address_search_sequencer_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire rass_pkg::req_t  in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output rass_pkg::rsp_t       out_data,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [15:0]     cfg_data
);

    rass_pkg::cfg_t      cfg_reg;
    rass_pkg::rsp_t      seq_rsp;
    rass_pkg::rsp_t      rsp_reg;
    rass_pkg::store_wr_t wr;
    logic                fire;
    logic                hit;
    logic                hit_reg;
    logic                rd_reg;
    logic                valid_reg;
    logic [31:0]         rdata;

    assign in_ready = !valid_reg || out_ready;
    assign fire = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.init_address_mode <= 8'd0;
            cfg_reg.randomize_enable <= 1'b0;
            cfg_reg.global_timeout_ticks <= 16'd600;
            cfg_reg.device_timeout_ticks <= 8'd30;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                rass_pkg::CFG_INIT_MODE: cfg_reg.init_address_mode <= cfg_data[7:0];
                rass_pkg::CFG_RAND_EN:   cfg_reg.randomize_enable <= cfg_data[0];
                rass_pkg::CFG_GLOBAL_TO: cfg_reg.global_timeout_ticks <= cfg_data;
                rass_pkg::CFG_DEVICE_TO: cfg_reg.device_timeout_ticks <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    rass_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .req       (in_data),
        .cfg       (cfg_reg),
        .rsp       (seq_rsp),
        .entry_hit (hit),
        .wr        (wr)
    );

    rass_ram #(
        .Width (32),
        .Depth (rass_pkg::MaxDevices)
    ) u_store (
        .clk   (clk),
        .we    (wr.we),
        .waddr (wr.waddr),
        .wdata (wr.wdata),
        .raddr (in_data.entry_index[rass_pkg::IdxW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            rsp_reg <= seq_rsp;
            hit_reg <= hit;
            rd_reg <= (in_data.command == rass_pkg::CMD_READ);
        end
    end

    logic [31:0] rdata_hold;
    logic        fresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh_reg <= 1'b0;
        end
        else
        begin
            fresh_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fresh_reg)
        begin
            rdata_hold <= rdata;
        end
    end

    logic [31:0] entry;

    always_comb
    begin
        entry = fresh_reg ? rdata : rdata_hold;
        out_data = rsp_reg;
        if (rd_reg)
        begin
            out_data.entry_high  = hit_reg ? entry[31:24] : 8'hFF;
            out_data.entry_mid   = hit_reg ? entry[23:16] : 8'hFF;
            out_data.entry_low   = hit_reg ? entry[15:8]  : 8'hFF;
            out_data.entry_short = hit_reg ? entry[7:0]   : 8'hFF;
        end
    end

    assign out_valid = valid_reg;

`ifndef SYNTHESIS
    a_start_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.start_accepted) |-> (out_data.run_status == rass_pkg::ST_RUN))
        else $error("start accepted without a running status");
    a_release_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.release_lock) |-> (out_data.frame_kind == 4'd0))
        else $error("lock released together with a frame");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.found_count <= 7'd65))
        else $error("found count out of range");
`endif

endmodule
`default_nettype wire
